/* rtl/core/ps2sa_pkg.sv */
`timescale 1ns / 1ps

package ps2sa_pkg;

  // Default FIFO slot count; the FIFO holds one fewer character than this
  localparam int unsigned FifoDepthDefault = 64;

  // Command codes
  typedef enum logic [1:0] {
    CMD_SCAN  = 2'd0,
    CMD_POP   = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  // Set 1 scan codes of interest
  localparam logic [7:0] ScPrefix = 8'hE0;
  localparam logic [6:0] ScLShift = 7'h2A;
  localparam logic [6:0] ScRShift = 7'h36;
  localparam logic [6:0] ScLCtrl  = 7'h1D;
  localparam logic [6:0] ScLAlt   = 7'h38;
  localparam logic [6:0] ScCaps   = 7'h3A;
  localparam int unsigned MapLen  = 58;

  localparam logic [6:0] ChLowA = 7'h61;
  localparam logic [6:0] ChLowZ = 7'h7A;
  localparam logic [6:0] ChUpA  = 7'h41;
  localparam logic [6:0] ChUpZ  = 7'h5A;
  localparam logic [6:0] ChNone = 7'h00;

  // Key tables indexed by make code
  localparam logic [6:0] PlainMap [MapLen] = '{
    7'h00, 7'h00, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38,
    7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09, 7'h71, 7'h77, 7'h65, 7'h72,
    7'h74, 7'h79, 7'h75, 7'h69, 7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h00,
    7'h61, 7'h73, 7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
    7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76, 7'h62, 7'h6E,
    7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h2A, 7'h00, 7'h20
  };

  localparam logic [6:0] ShiftMap [MapLen] = '{
    7'h00, 7'h00, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E, 7'h26, 7'h2A,
    7'h28, 7'h29, 7'h5F, 7'h2B, 7'h08, 7'h09, 7'h51, 7'h57, 7'h45, 7'h52,
    7'h54, 7'h59, 7'h55, 7'h49, 7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0A, 7'h00,
    7'h41, 7'h53, 7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3A,
    7'h22, 7'h7E, 7'h00, 7'h7C, 7'h5A, 7'h58, 7'h43, 7'h56, 7'h42, 7'h4E,
    7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h2A, 7'h00, 7'h20
  };

  // Keyboard modifier state
  typedef struct packed {
    logic shift;
    logic ctrl;
    logic alt;
    logic caps;
    logic prefix;
  } mods_t;

  // Input word
  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] scan_byte;
  } in_word_t;

  // Result word
  typedef struct packed {
    logic [6:0] char_out;
    logic       char_valid;
    logic       key_waiting;
    logic       char_stored;
    logic       char_dropped;
    logic       shift_held;
    logic       ctrl_held;
    logic       alt_held;
    logic       caps_on;
  } out_word_t;

endpackage

/* rtl/core/ps2sa_decode.sv */
`timescale 1ns / 1ps

module ps2sa_decode (
  input  logic [7:0]      scan_byte_i,
  input  ps2sa_pkg::mods_t mods_i,
  output ps2sa_pkg::mods_t mods_o,
  output logic [6:0]      char_o
);

  logic [6:0] code;
  logic [6:0] mapped;
  logic [6:0] cased;
  logic       in_map;

  assign code   = scan_byte_i[6:0];
  assign in_map = (scan_byte_i < 8'(ps2sa_pkg::MapLen));

  // Look up the plain or shifted table
  always_comb begin
    mapped = ps2sa_pkg::ChNone;
    if (in_map) begin
      mapped = mods_i.shift ? ps2sa_pkg::ShiftMap[code[5:0]]
                            : ps2sa_pkg::PlainMap[code[5:0]];
    end
  end

  // Invert letter case under caps lock, then under ctrl fold lowercase letters to control codes
  always_comb begin
    cased = mapped;
    if (mods_i.caps && (((mapped >= ps2sa_pkg::ChLowA) && (mapped <= ps2sa_pkg::ChLowZ))
        || ((mapped >= ps2sa_pkg::ChUpA) && (mapped <= ps2sa_pkg::ChUpZ)))) begin
      cased = mapped ^ 7'h20;
    end
    if (mods_i.ctrl && (cased >= ps2sa_pkg::ChLowA) && (cased <= ps2sa_pkg::ChLowZ)) begin
      cased = cased - 7'h60;
    end
  end

  // Track modifiers; only a plain make code of a character key yields a character
  always_comb begin
    mods_o = mods_i;
    char_o = ps2sa_pkg::ChNone;
    priority if (scan_byte_i == ps2sa_pkg::ScPrefix) begin
      mods_o.prefix = 1'b1;
    end else if (scan_byte_i[7]) begin
      if ((code == ps2sa_pkg::ScLShift) || (code == ps2sa_pkg::ScRShift)) begin
        mods_o.shift = 1'b0;
      end else if (code == ps2sa_pkg::ScLCtrl) begin
        mods_o.ctrl = 1'b0;
      end else if (code == ps2sa_pkg::ScLAlt) begin
        mods_o.alt = 1'b0;
      end
      mods_o.prefix = 1'b0;
    end else if (mods_i.prefix) begin
      mods_o.prefix = 1'b0;
    end else if ((code == ps2sa_pkg::ScLShift) || (code == ps2sa_pkg::ScRShift)) begin
      mods_o.shift = 1'b1;
    end else if (code == ps2sa_pkg::ScLCtrl) begin
      mods_o.ctrl = 1'b1;
    end else if (code == ps2sa_pkg::ScLAlt) begin
      mods_o.alt = 1'b1;
    end else if (code == ps2sa_pkg::ScCaps) begin
      mods_o.caps = ~mods_i.caps;
    end else begin
      char_o = cased;
    end
  end

endmodule

/* rtl/core/ps2_scancode_to_ascii_fifo_unit.sv */
`timescale 1ns / 1ps
// A result word is registered and shows in the cycle after its input word is accepted.
// Throughput: one word per cycle; the result register parts the two sides, so
// a new word is taken whenever the result register is empty or being drained.
// Reset clears modifier flags, FIFO pointers and the result register; the
// character store is not cleared and is only read behind the write pointer.

module ps2_scancode_to_ascii_fifo_unit #(
  parameter int unsigned FIFO_DEPTH = ps2sa_pkg::FifoDepthDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  ps2sa_pkg::in_word_t  in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output ps2sa_pkg::out_word_t out_data_o
);

  localparam int unsigned IdxW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(FIFO_DEPTH - 1);

  logic [6:0] store_q [FIFO_DEPTH];

  logic [IdxW-1:0]      rd_idx_q, rd_idx_d, wr_idx_q, wr_idx_d;
  logic [IdxW-1:0]      rd_next, wr_next;
  ps2sa_pkg::mods_t     mods_q, mods_d, mods_dec;
  ps2sa_pkg::out_word_t res_q, res_d;
  logic                 out_valid_q;
  logic [6:0]           pop_char_q;
  logic [6:0]           dec_char;
  logic                 accept;
  logic                 do_push;
  logic                 do_pop;
  logic                 fifo_full;
  logic                 fifo_empty;

  assign in_ready_o = ~out_valid_q | out_ready_i;
  assign accept     = in_valid_i & in_ready_o;

  ps2sa_decode u_decode (
    .scan_byte_i (in_data_i.scan_byte),
    .mods_i      (mods_q),
    .mods_o      (mods_dec),
    .char_o      (dec_char)
  );

  // Ring pointer arithmetic
  assign rd_next    = (rd_idx_q == LastIdx) ? '0 : rd_idx_q + 1'b1;
  assign wr_next    = (wr_idx_q == LastIdx) ? '0 : wr_idx_q + 1'b1;
  assign fifo_full  = (wr_next == rd_idx_q);
  assign fifo_empty = (rd_idx_q == wr_idx_q);

  // Apply one command to flags and pointers, and form the result word
  always_comb begin
    mods_d   = mods_q;
    rd_idx_d = rd_idx_q;
    wr_idx_d = wr_idx_q;
    do_push  = 1'b0;
    do_pop   = 1'b0;
    res_d    = '0;
    unique case (in_data_i.cmd)
      ps2sa_pkg::CMD_SCAN: begin
        mods_d = mods_dec;
        if (dec_char != ps2sa_pkg::ChNone) begin
          if (!fifo_full) begin
            do_push           = 1'b1;
            wr_idx_d          = wr_next;
            res_d.char_stored = 1'b1;
          end else begin
            res_d.char_dropped = 1'b1;
          end
        end
      end
      ps2sa_pkg::CMD_POP: begin
        if (!fifo_empty) begin
          do_pop           = 1'b1;
          rd_idx_d         = rd_next;
          res_d.char_valid = 1'b1;
        end
      end
      ps2sa_pkg::CMD_CLEAR: begin
        rd_idx_d = '0;
        wr_idx_d = '0;
      end
      ps2sa_pkg::CMD_NONE: begin
      end
      default: begin
      end
    endcase
    res_d.key_waiting = (rd_idx_d != wr_idx_d);
    res_d.shift_held  = mods_d.shift;
    res_d.ctrl_held   = mods_d.ctrl;
    res_d.alt_held    = mods_d.alt;
    res_d.caps_on     = mods_d.caps;
  end

  // Hold state and the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mods_q      <= '0;
      rd_idx_q    <= '0;
      wr_idx_q    <= '0;
      out_valid_q <= 1'b0;
      res_q       <= '0;
    end else begin
      if (accept) begin
        mods_q      <= mods_d;
        rd_idx_q    <= rd_idx_d;
        wr_idx_q    <= wr_idx_d;
        res_q       <= res_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Character store: write at the tail, registered read at the head
  always_ff @(posedge clk_i) begin
    if (accept && do_push) begin
      store_q[wr_idx_q] <= dec_char;
    end
    if (accept && do_pop) begin
      pop_char_q <= store_q[rd_idx_q];
    end
  end

  // Drive the result word; the popped character shows only on a good pop
  always_comb begin
    out_data_o          = res_q;
    out_data_o.char_out = res_q.char_valid ? pop_char_q : ps2sa_pkg::ChNone;
  end

  assign out_valid_o = out_valid_q;

endmodule

/* rtl/core/ps2sa_checker.sv */
`timescale 1ns / 1ps

module ps2sa_checker (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_ready_o,
  input ps2sa_pkg::in_word_t  in_data_i,
  input logic                 out_valid_o,
  input logic                 out_ready_i,
  input ps2sa_pkg::out_word_t out_data_o
);

  // Hold a stalled result word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(out_data_o)))
    else $error("result word changed while stalled");

  // Stop taking input while the result register is stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |-> !in_ready_o)
    else $error("input taken over a stalled result");

  // A character is either queued or dropped, never both
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_data_o.char_stored && out_data_o.char_dropped))
    else $error("character both stored and dropped");

  // No character shows without a good pop
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.char_valid) |-> (out_data_o.char_out == 7'h00))
    else $error("character shown without a good pop");

  // A clear leaves the FIFO empty in its result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && (in_data_i.cmd == ps2sa_pkg::CMD_CLEAR))
    |=> (out_valid_o && !out_data_o.key_waiting))
    else $error("key waiting after clear");

endmodule

bind ps2_scancode_to_ascii_fifo_unit ps2sa_checker u_ps2sa_checker (.*);
